// ===== rtl/dq_pkg.sv =====
// Shared types and constants for the double-ended queue.
`default_nettype none

package dq_pkg;

    // Slot count is a power of two so pointers wrap by truncation.
    localparam int ADDR_W   = 4;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int CNT_W    = ADDR_W + 1;
    localparam int DATA_W   = 32;
    localparam int ACT_W    = 2;
    localparam int ST_W     = 2;
    localparam int OUT_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic take;     // word accepted this cycle
        logic load_rd;  // RAM read data valid, capture into result
    } t_dq_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic needs_read;  // current input is a pop on a non-empty queue
        logic full;
        logic empty;
    } t_dq_stat;

endpackage

`default_nettype wire

// ===== rtl/dq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/dq_ctrl.sv =====
// Controller: handshake, result-valid flag and pop read sequencing.
`default_nettype none

module dq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    input  wire logic            i_m_tready,
    input  wire dq_pkg::t_dq_stat i_stat,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    output dq_pkg::t_dq_cmd      o_cmd,
    output dq_pkg::t_state       o_state
);

    dq_pkg::t_state r_state, n_state;
    logic           r_out_valid, n_out_valid;
    logic           s_tready;
    dq_pkg::t_dq_cmd cmd;

    // Outputs
    always_comb begin
        s_tready    = 1'b0;
        cmd.take    = 1'b0;
        cmd.load_rd = 1'b0;
        case (r_state)
            dq_pkg::S_IDLE: begin
                s_tready = !r_out_valid || i_m_tready;
                cmd.take = i_s_tvalid && s_tready;
            end
            dq_pkg::S_READ: begin
                cmd.load_rd = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dq_pkg::S_IDLE: begin
                if (cmd.take && i_stat.needs_read) begin
                    n_state = dq_pkg::S_READ;
                end
            end
            dq_pkg::S_READ: begin
                n_state = dq_pkg::S_IDLE;
            end
            default: begin
                n_state = dq_pkg::S_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if ((cmd.take && !i_stat.needs_read) || cmd.load_rd) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = cmd;
    assign o_state    = r_state;

endmodule

`default_nettype wire

// ===== rtl/dq_dpath.sv =====
// Datapath: head pointer, count, slot RAM and result registers.
`default_nettype none

module dq_dpath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire dq_pkg::t_dq_cmd             i_cmd,
    input  wire dq_pkg::t_action             i_action,
    input  wire logic [dq_pkg::DATA_W-1:0]   i_value,
    output dq_pkg::t_dq_stat                 o_stat,
    output dq_pkg::t_status                  o_status,
    output logic      [dq_pkg::DATA_W-1:0]   o_popped,
    output logic      [dq_pkg::CNT_W-1:0]    o_occ
);

    logic [dq_pkg::ADDR_W-1:0] r_head, n_head;
    logic [dq_pkg::CNT_W-1:0]  r_count, n_count;

    dq_pkg::t_status           r_status, n_status;
    logic [dq_pkg::DATA_W-1:0] r_popped;
    logic [dq_pkg::CNT_W-1:0]  r_occ;

    logic                      full, empty, needs_read;
    logic                      we, re;
    logic [dq_pkg::ADDR_W-1:0] waddr, raddr, tail;
    logic [dq_pkg::DATA_W-1:0] rdata;

    assign full  = r_count[dq_pkg::ADDR_W];
    assign empty = (r_count == '0);
    // slot just past the rear word
    assign tail  = r_head + r_count[dq_pkg::ADDR_W-1:0];

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_status   = dq_pkg::ST_OK;
        needs_read = 1'b0;
        we         = 1'b0;
        waddr      = tail;
        raddr      = r_head;
        case (i_action)
            dq_pkg::ACT_PUSH_FRONT: begin
                if (full) begin
                    n_status = dq_pkg::ST_FULL;
                end else begin
                    n_head  = r_head - dq_pkg::ADDR_W'(1);
                    waddr   = r_head - dq_pkg::ADDR_W'(1);
                    we      = 1'b1;
                    n_count = r_count + dq_pkg::CNT_W'(1);
                end
            end
            dq_pkg::ACT_PUSH_REAR: begin
                if (full) begin
                    n_status = dq_pkg::ST_FULL;
                end else begin
                    waddr   = tail;
                    we      = 1'b1;
                    n_count = r_count + dq_pkg::CNT_W'(1);
                end
            end
            dq_pkg::ACT_POP_FRONT: begin
                if (empty) begin
                    n_status = dq_pkg::ST_EMPTY;
                end else begin
                    raddr      = r_head;
                    needs_read = 1'b1;
                    n_head     = r_head + dq_pkg::ADDR_W'(1);
                    n_count    = r_count - dq_pkg::CNT_W'(1);
                end
            end
            dq_pkg::ACT_POP_REAR: begin
                if (empty) begin
                    n_status = dq_pkg::ST_EMPTY;
                end else begin
                    raddr      = tail - dq_pkg::ADDR_W'(1);
                    needs_read = 1'b1;
                    n_count    = r_count - dq_pkg::CNT_W'(1);
                end
            end
            default: begin
                n_status = dq_pkg::ST_OK;
            end
        endcase
    end

    assign re = i_cmd.take && needs_read;

    dq_ram #(
        .WIDTH (dq_pkg::DATA_W),
        .DEPTH (dq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && we),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.take) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_status <= n_status;
            r_occ    <= n_count;
            r_popped <= '0;
        end else if (i_cmd.load_rd) begin
            r_popped <= rdata;
        end
    end

    assign o_stat.needs_read = needs_read;
    assign o_stat.full       = full;
    assign o_stat.empty      = empty;
    assign o_status          = r_status;
    assign o_popped          = r_popped;
    assign o_occ             = r_occ;

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue_core.sv =====
// Top level of the double-ended queue: controller, datapath and checks.
`default_nettype none

// Channel  Dir  tdata (low bit up)                          tuser
// s        in   value[31:0]                                 action[1:0]
// m        out  popped_value[31:0], occupancy[36:32],       status[1:0]
//               zero pad [39:37]
//
// For push words (and any rejected operation) the result is registered at the
// accept edge. A successful pop reads the slot RAM's registered read port,
// then S_READ captures it into the result; no word is accepted meanwhile.
// A new word is accepted while a finished result is being taken on m.
// Synchronous active-low reset clears head and count; slot contents are
// not cleared, a slot is only read after a push wrote it.
// A stalled result (m_tready low) holds and blocks new words once held.

module double_ended_queue_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave side
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [dq_pkg::DATA_W-1:0]       i_s_tdata,  // value
    input  wire logic [dq_pkg::ACT_W-1:0]        i_s_tuser,  // action
    // master side
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic      [dq_pkg::OUT_TDATA_W-1:0]  o_m_tdata,  // popped_value, occupancy
    output logic      [dq_pkg::ST_W-1:0]         o_m_tuser   // status
);

    dq_pkg::t_dq_cmd           cmd;
    dq_pkg::t_dq_stat          stat;
    dq_pkg::t_state            state;
    dq_pkg::t_status           status;
    logic [dq_pkg::DATA_W-1:0] popped;
    logic [dq_pkg::CNT_W-1:0]  occ;

    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    dq_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_action (dq_pkg::t_action'(i_s_tuser)),
        .i_value  (i_s_tdata),
        .o_stat   (stat),
        .o_status (status),
        .o_popped (popped),
        .o_occ    (occ)
    );

    assign o_m_tuser = status;
    assign o_m_tdata = {
        (dq_pkg::OUT_TDATA_W - dq_pkg::DATA_W - dq_pkg::CNT_W)'(0), occ, popped
    };

    // A successful pop passes through S_READ, with no result shown there, before its result shows.
    a_pop_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.take && stat.needs_read) |=> (!o_m_tvalid && state == dq_pkg::S_READ)
            ##1 o_m_tvalid)
        else $error("pop result timing broken");

    // Any other accepted word has its result at the next edge.
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.take && !stat.needs_read) |=> o_m_tvalid)
        else $error("result missing after accept");

    // A full rejection reports full occupancy, an empty one reports zero.
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && status == dq_pkg::ST_FULL) |-> occ == dq_pkg::CNT_W'(dq_pkg::DEPTH))
        else $error("full status with wrong occupancy");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && status == dq_pkg::ST_EMPTY) |-> (occ == '0 && popped == '0))
        else $error("empty status with stored words or data");

    // While full, the queue is not empty and the occupancy never passes the slot count.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.full |-> !stat.empty && occ <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
        else $error("count out of range");

endmodule

`default_nettype wire
